[src/swr_pkg.sv]
package swr_pkg;

   // widths fixed by the word format
   localparam int AxisW   = 8;
   localparam int IdxW    = 64;
   localparam int DimW    = 31;
   localparam int AxOutW  = 3;
   localparam int ErrW    = 2;
   localparam int RankW   = 4;
   localparam int EntryW  = 4;
   localparam int CsrIdxW = 2;

   // error codes
   localparam logic [ErrW-1:0] ERR_OK   = 2'd0;
   localparam logic [ErrW-1:0] ERR_AXIS = 2'd1;
   localparam logic [ErrW-1:0] ERR_STEP = 2'd2;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_RANK  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_AXES  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_STEPS = 2'd2;

   // register reset values
   localparam logic [RankW-1:0] RankReset  = 4'd8;
   localparam logic             AxesReset  = 1'b1;
   localparam logic             StepsReset = 1'b1;

   // front/back queue depth and divider length (one quotient bit per cycle)
   localparam int QDepth   = 2;
   localparam int DivSteps = DimW;

   typedef struct packed {
      logic [RankW-1:0] rank;
      logic             axes_given;
      logic             steps_given;
   } cfg_type;

   // classified entry handed from front to back
   typedef struct packed {
      logic [AxOutW-1:0] axis;
      logic [DimW-1:0]   start;
      logic [IdxW-1:0]   stride;
      logic [DimW-1:0]   span;
      logic [IdxW-1:0]   mag;
      logic [DimW-1:0]   out_dim;
      logic [ErrW-1:0]   err;
      logic              last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[src/swr_front.sv]
module swr_front
   import swr_pkg::*;
#(
   parameter int MAX_RANK = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   push,
   output logic                   full,
   input  logic signed [AxisW-1:0] axis,
   input  logic signed [IdxW-1:0] start_req,
   input  logic signed [IdxW-1:0] finish,
   input  logic signed [IdxW-1:0] stride,
   input  logic [DimW-1:0]        dim,
   input  logic [DimW-1:0]        out_dim,
   input  logic                   last_entry,
   input  q_status_type           q_stat,
   output logic                   q_wr,
   output entry_type              q_wdata
);

   typedef enum logic [1:0] {
      F_IDLE  = 2'b01,
      F_CLAMP = 2'b10
   } fstate_type;

   localparam logic [4:0] MaxRankW = 5'(MAX_RANK);

   fstate_type fstate_ff, fstate_in;

   logic [MAX_RANK-1:0] used_ff, used_in;
   logic [EntryW-1:0]   entry_ff, entry_in;

   // stage 1 capture
   logic [AxOutW-1:0]     ax_ff;
   logic [ErrW-1:0]       err_ff;
   logic                  last_ff;
   logic [IdxW-1:0]       step_ff;
   logic signed [IdxW:0]  st_w_ff, en_w_ff;
   logic [DimW-1:0]       dim_ff, odim_ff;

   logic                  accept;
   logic [4:0]            rank_sat;
   logic signed [9:0]     ax_raw, ax_wrap;
   logic                  ax_ok, dup;
   logic [MAX_RANK-1:0]   hit;
   logic [IdxW-1:0]       step_use;
   logic [ErrW-1:0]       err_new;
   logic signed [IdxW:0]  dim_ext, st_ext, en_ext, st_w, en_w;

   // stage 2 clamp
   logic                  pos, zneg, ok;
   logic signed [IdxW:0]  dim65, hi, en_lo, st_c, en_c, diff;
   logic [DimW-1:0]       span;

   assign full   = (fstate_ff != F_IDLE);
   assign accept = push && !full;

   always_comb begin
      rank_sat = ({1'b0, cfg.rank} > MaxRankW) ? MaxRankW : {1'b0, cfg.rank};
      ax_raw   = cfg.axes_given ? {{2{axis[AxisW-1]}}, axis} : {6'b0, entry_ff};
      ax_wrap  = ax_raw[9] ? (ax_raw + $signed({5'b0, rank_sat})) : ax_raw;
      ax_ok    = !ax_wrap[9] && (ax_wrap[8:0] < {4'b0, rank_sat});
      for (int i = 0; i < MAX_RANK; i++) begin
         hit[i] = ax_ok && (ax_wrap[8:0] == 9'(i));
      end
      dup      = |(hit & used_ff);
      step_use = cfg.steps_given ? stride : 64'd1;
      if (!ax_ok || dup) begin
         err_new = ERR_AXIS;
      end else if (step_use == '0) begin
         err_new = ERR_STEP;
      end else begin
         err_new = ERR_OK;
      end
      // negative indexes count back from the dimension
      dim_ext = $signed({34'b0, dim});
      st_ext  = {start_req[IdxW-1], start_req};
      en_ext  = {finish[IdxW-1], finish};
      st_w    = start_req[IdxW-1] ? (st_ext + dim_ext) : st_ext;
      en_w    = finish[IdxW-1] ? (en_ext + dim_ext) : en_ext;
   end

   always_comb begin
      used_in  = used_ff;
      entry_in = entry_ff;
      if (accept) begin
         if (err_new != ERR_AXIS) begin
            used_in = used_ff | hit;
         end
         if (last_entry) begin
            used_in  = '0;
            entry_in = '0;
         end else if (entry_ff != {EntryW{1'b1}}) begin
            entry_in = entry_ff + 1'b1;
         end
      end
   end

   always_comb begin
      pos   = !step_ff[IdxW-1];
      zneg  = !pos && (dim_ff == '0);
      ok    = (err_ff == ERR_OK);
      dim65 = $signed({34'b0, dim_ff});
      hi    = pos ? dim65 : (dim65 - 65'sd1);
      en_lo = pos ? 65'sd0 : -65'sd1;
      if (zneg || st_w_ff < 65'sd0) begin
         st_c = '0;
      end else if (st_w_ff > hi) begin
         st_c = hi;
      end else begin
         st_c = st_w_ff;
      end
      if (en_w_ff < en_lo) begin
         en_c = en_lo;
      end else if (en_w_ff > hi) begin
         en_c = hi;
      end else begin
         en_c = en_w_ff;
      end
      diff = pos ? (en_c - st_c) : (st_c - en_c);
      span = (zneg || !ok || diff <= 65'sd0) ? '0 : diff[DimW-1:0];

      q_wdata.axis    = ok ? ax_ff : '0;
      q_wdata.start   = ok ? st_c[DimW-1:0] : '0;
      q_wdata.stride  = ok ? step_ff : '0;
      q_wdata.span    = span;
      q_wdata.mag     = pos ? step_ff : (64'd0 - step_ff);
      q_wdata.out_dim = odim_ff;
      q_wdata.err     = err_ff;
      q_wdata.last    = last_ff;
   end

   assign q_wr = (fstate_ff == F_CLAMP) && !q_stat.full;

   always_comb begin
      fstate_in = fstate_ff;
      unique case (fstate_ff)
         F_IDLE:  if (accept) fstate_in = F_CLAMP;
         F_CLAMP: if (q_wr) fstate_in = F_IDLE;
         default: fstate_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fstate_ff <= F_IDLE;
         used_ff   <= '0;
         entry_ff  <= '0;
      end else begin
         fstate_ff <= fstate_in;
         used_ff   <= used_in;
         entry_ff  <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff   <= ax_wrap[AxOutW-1:0];
         err_ff  <= err_new;
         last_ff <= last_entry;
         step_ff <= step_use;
         st_w_ff <= st_w;
         en_w_ff <= en_w;
         dim_ff  <= dim;
         odim_ff <= out_dim;
      end
   end

endmodule

[src/swr_queue.sv]
module swr_queue
   import swr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr,
   input  entry_type    wdata,
   input  logic         rd,
   output entry_type    rdata,
   output q_status_type stat
);

   localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int CntW = $clog2(QDepth + 1);

   entry_type         mem [QDepth];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   cnt_ff;
   logic              do_wr, do_rd;

   assign stat.full  = (cnt_ff == CntW'(QDepth));
   assign stat.empty = (cnt_ff == '0);
   assign do_wr      = wr && !stat.full;
   assign do_rd      = rd && !stat.empty;
   assign rdata      = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

[src/swr_back.sv]
module swr_back
   import swr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  q_status_type          q_stat,
   input  entry_type             q_rdata,
   output logic                  q_rd,
   output logic                  empty,
   input  logic                  pop,
   output logic [AxOutW-1:0]     axis_out,
   output logic [DimW-1:0]       start_out,
   output logic signed [IdxW-1:0] stride_out,
   output logic [DimW-1:0]       extent,
   output logic [ErrW-1:0]       error,
   output logic                  last_out
);

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_DIV  = 4'b0010,
      B_FIN  = 4'b0100,
      B_DONE = 4'b1000
   } bstate_type;

   localparam int CntW = $clog2(DivSteps);

   bstate_type bstate_ff, bstate_in;

   entry_type         cur_ff;
   logic [DimW-1:0]   nq_ff;    // numerator in, quotient out
   logic [DimW:0]     rem_ff;
   logic [DimW-1:0]   div_ff;
   logic              zero_ff;
   logic [CntW-1:0]   cnt_ff;

   logic [DimW:0]     rem_sh, ext_sum;
   logic              ge, big;
   logic [DimW-1:0]   ext_cap;

   assign q_rd  = (bstate_ff == B_IDLE) && !q_stat.empty;
   assign empty = (bstate_ff != B_DONE);
   assign big   = |q_rdata.mag[IdxW-1:DimW];

   always_comb begin
      rem_sh  = {rem_ff[DimW-1:0], nq_ff[DimW-1]};
      ge      = (rem_sh >= {1'b0, div_ff});
      ext_sum = zero_ff ? '0 : ({1'b0, nq_ff} + 1'b1);
      ext_cap = (ext_sum > {1'b0, cur_ff.out_dim}) ? cur_ff.out_dim : ext_sum[DimW-1:0];
   end

   always_comb begin
      bstate_in = bstate_ff;
      unique case (bstate_ff)
         B_IDLE: begin
            if (q_rd) begin
               bstate_in = (q_rdata.span == '0 || big) ? B_FIN : B_DIV;
            end
         end
         B_DIV:  if (cnt_ff == CntW'(DivSteps - 1)) bstate_in = B_FIN;
         B_FIN:  bstate_in = B_DONE;
         B_DONE: if (pop) bstate_in = B_IDLE;
         default: bstate_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff <= B_IDLE;
      end else begin
         bstate_ff <= bstate_in;
      end
   end

   // ceil(span / mag) = (span - 1) / mag + 1, restoring, one bit a cycle
   always_ff @(posedge clock) begin
      unique case (bstate_ff)
         B_IDLE: begin
            cur_ff  <= q_rdata;
            nq_ff   <= big ? '0 : (q_rdata.span - 1'b1);
            div_ff  <= q_rdata.mag[DimW-1:0];
            zero_ff <= (q_rdata.span == '0);
            rem_ff  <= '0;
            cnt_ff  <= '0;
         end
         B_DIV: begin
            rem_ff <= ge ? (rem_sh - {1'b0, div_ff}) : rem_sh;
            nq_ff  <= {nq_ff[DimW-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
         end
         B_FIN: begin
            axis_out   <= cur_ff.axis;
            start_out  <= cur_ff.start;
            stride_out <= cur_ff.stride;
            extent     <= ext_cap;
            error      <= cur_ff.err;
            last_out   <= cur_ff.last;
         end
         B_DONE: ;
         default: ;
      endcase
   end

endmodule

[src/slice_window_resolver_core.sv]
// Slice window resolver: one slice entry in, one resolved entry out.
//
// Input channel: drive the entry on req_* with push high; the word is taken
// at a clock edge where push is high and full is low. Result channel: while
// empty is low the oldest result sits on rsp_*; raise pop to take it.
// Configuration: csr_wr_en with csr_index/csr_wdata writes rank (0),
// axes_given (1) or steps_given (2); write only while idle.
//
// From accept to empty going low a word passes the front (clamp; the axis
// and index wrap settle before the accept edge), the hand-over through the
// queue, the bit-serial divider that forms the extent, and the register that
// caps and holds it. The front can take new words while the back divides,
// until the queue fills. Entries whose span is zero, that carry an error, or
// whose step exceeds 31 bits skip the divider. A two-entry queue between
// front and back lets the front keep taking words while a result waits on a
// stalled receiver.
// Reset (synchronous, active high) empties the queue, clears the used-axis
// map and entry position, and loads rank 8 with axes and steps given.
module slice_window_resolver_core
   import swr_pkg::*;
#(
   parameter int MAX_RANK = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [CsrIdxW-1:0]     csr_index,
   input  logic [RankW-1:0]       csr_wdata,
   // input words
   input  logic                   push,
   output logic                   full,
   input  logic signed [AxisW-1:0] req_axis,
   input  logic signed [IdxW-1:0] req_start_req,
   input  logic signed [IdxW-1:0] req_finish,
   input  logic signed [IdxW-1:0] req_stride,
   input  logic [DimW-1:0]        req_dim,
   input  logic [DimW-1:0]        req_out_dim,
   input  logic                   req_last_entry,
   // result words
   output logic                   empty,
   input  logic                   pop,
   output logic [AxOutW-1:0]      rsp_axis_out,
   output logic [DimW-1:0]        rsp_start_out,
   output logic signed [IdxW-1:0] rsp_stride_out,
   output logic [DimW-1:0]        rsp_extent,
   output logic [ErrW-1:0]        rsp_error,
   output logic                   rsp_last_out
);

   cfg_type      cfg_ff;
   q_status_type q_stat;
   logic         q_wr, q_rd;
   entry_type    q_wdata, q_rdata;

   // config registers, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rank        <= RankReset;
         cfg_ff.axes_given  <= AxesReset;
         cfg_ff.steps_given <= StepsReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RANK:  cfg_ff.rank        <= csr_wdata;
            CSR_AXES:  cfg_ff.axes_given  <= csr_wdata[0];
            CSR_STEPS: cfg_ff.steps_given <= csr_wdata[0];
            default:   ;   // unmapped index, dropped
         endcase
      end
   end

   // front: axis resolve, duplicate check, wrap and clamp
   swr_front #(
      .MAX_RANK (MAX_RANK)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (push),
      .full       (full),
      .axis       (req_axis),
      .start_req  (req_start_req),
      .finish     (req_finish),
      .stride     (req_stride),
      .dim        (req_dim),
      .out_dim    (req_out_dim),
      .last_entry (req_last_entry),
      .q_stat     (q_stat),
      .q_wr       (q_wr),
      .q_wdata    (q_wdata)
   );

   swr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .wdata (q_wdata),
      .rd    (q_rd),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   // back: extent divide, cap, result register
   swr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_rdata    (q_rdata),
      .q_rd       (q_rd),
      .empty      (empty),
      .pop        (pop),
      .axis_out   (rsp_axis_out),
      .start_out  (rsp_start_out),
      .stride_out (rsp_stride_out),
      .extent     (rsp_extent),
      .error      (rsp_error),
      .last_out   (rsp_last_out)
   );

   // an erroring word carries no window
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_error != ERR_OK) |->
         (rsp_extent == '0 && rsp_start_out == '0 && rsp_stride_out == '0))
      else $error("error word with nonzero window");

   // only defined error codes leave the block
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_error == ERR_OK || rsp_error == ERR_AXIS || rsp_error == ERR_STEP))
      else $error("undefined error code");

   // nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (empty && !full))
      else $error("block not empty after reset");

endmodule

[dv/slice_window_checker.sv]
`timescale 1ns / 100ps

module slice_window_checker
   import swr_pkg::*;
#(
   parameter int MaxRank = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CsrIdxW-1:0]      csr_index,
   input  logic [RankW-1:0]        csr_wdata,
   input  logic                    push,
   input  logic                    full,
   input  logic signed [AxisW-1:0] req_axis,
   input  logic signed [IdxW-1:0]  req_start_req,
   input  logic signed [IdxW-1:0]  req_finish,
   input  logic signed [IdxW-1:0]  req_stride,
   input  logic [DimW-1:0]         req_dim,
   input  logic [DimW-1:0]         req_out_dim,
   input  logic                    req_last_entry,
   input  logic                    empty,
   input  logic                    pop,
   input  logic [AxOutW-1:0]       rsp_axis_out,
   input  logic [DimW-1:0]         rsp_start_out,
   input  logic signed [IdxW-1:0]  rsp_stride_out,
   input  logic [DimW-1:0]         rsp_extent,
   input  logic [ErrW-1:0]         rsp_error,
   input  logic                    rsp_last_out,
   output int                      fail_count,
   output int                      pending_windows,
   output int                      windows_checked
);

   typedef struct packed {
      logic [AxOutW-1:0] axis_out;
      logic [DimW-1:0]   start_out;
      logic [IdxW-1:0]   stride_out;
      logic [DimW-1:0]   extent;
      logic [ErrW-1:0]   error;
      logic              last_out;
   } window_type;

   window_type predicted_windows[$];

   // shadow of the block's registers and run state
   logic [RankW-1:0]  rank_q;
   logic              axes_q;
   logic              steps_q;
   logic [7:0]        used_q;
   logic [EntryW-1:0] entry_q;
   int                result_no;

   function automatic longint clamp_index(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint unsigned ceil_quot(input longint unsigned a,
                                                 input longint unsigned m);
      if (a == 0) return 0;
      return (a - 1) / m + 1;
   endfunction

   // one slice entry in, the resolved window out; updates run state
   function automatic window_type resolve_entry(input logic signed [AxisW-1:0] axis_f,
                                                input logic signed [IdxW-1:0]  start_f,
                                                input logic signed [IdxW-1:0]  finish_f,
                                                input logic signed [IdxW-1:0]  stride_f,
                                                input logic [DimW-1:0]         dim_f,
                                                input logic [DimW-1:0]         odim_f,
                                                input logic                    last_f);
      window_type      res;
      int              r_eff;
      int              ax;
      longint          step;
      longint          st;
      longint          en;
      longint          dimv;
      longint          odimv;
      longint unsigned ext;
      res   = '0;
      ext   = 0;
      r_eff = (rank_q > MaxRank) ? MaxRank : int'(rank_q);
      dimv  = longint'(dim_f);
      odimv = longint'(odim_f);
      ax    = axes_q ? int'(axis_f) : int'(entry_q);
      if (ax < 0) ax += r_eff;
      step  = steps_q ? longint'(stride_f) : 64'sd1;
      res.last_out = last_f;
      if (ax < 0 || ax >= r_eff || used_q[ax]) begin
         res.error = ERR_AXIS;
      end else begin
         used_q[ax] = 1'b1;
         if (step == 0) begin
            res.error = ERR_STEP;
         end else begin
            st = start_f;
            en = finish_f;
            if (st < 0) st += dimv;
            if (en < 0) en += dimv;
            if (step > 0) begin
               st = clamp_index(st, 0, dimv);
               en = clamp_index(en, 0, dimv);
               if (en > st) ext = ceil_quot(en - st, step);
            end else if (dimv == 0) begin
               st = 0;
            end else begin
               st = clamp_index(st, 0, dimv - 1);
               en = clamp_index(en, -1, dimv - 1);
               if (st > en) ext = ceil_quot(st - en, 64'd0 - step);
            end
            if (ext > odimv) ext = odimv;
            res.axis_out   = ax[AxOutW-1:0];
            res.start_out  = st[DimW-1:0];
            res.stride_out = step;
            res.extent     = ext[DimW-1:0];
         end
      end
      if (last_f) begin
         used_q  = '0;
         entry_q = '0;
      end else if (entry_q != 4'd15) begin
         entry_q = entry_q + 1'b1;
      end
      return res;
   endfunction

   task automatic report(input string msg);
      $display("MISMATCH: %s", msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      window_type want;
      if (reset) begin
         predicted_windows.delete();
         rank_q     = RankReset;
         axes_q     = AxesReset;
         steps_q    = StepsReset;
         used_q     = '0;
         entry_q    = '0;
         result_no  = 0;
         fail_count = 0;
         pending_windows <= 0;
         windows_checked <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RANK:  rank_q  = csr_wdata;
               CSR_AXES:  axes_q  = csr_wdata[0];
               CSR_STEPS: steps_q = csr_wdata[0];
               default: ;
            endcase
         end
         if (pop && !empty) begin
            result_no++;
            if (predicted_windows.size() == 0) begin
               report($sformatf("result %0d arrived with no word expected", result_no));
            end else begin
               want = predicted_windows.pop_front();
               if (rsp_axis_out !== want.axis_out)
                  report($sformatf("result %0d axis_out %0d, expected %0d",
                                   result_no, rsp_axis_out, want.axis_out));
               if (rsp_start_out !== want.start_out)
                  report($sformatf("result %0d start_out %0d, expected %0d",
                                   result_no, rsp_start_out, want.start_out));
               if (rsp_stride_out !== want.stride_out)
                  report($sformatf("result %0d stride_out %0d, expected %0d",
                                   result_no, rsp_stride_out, $signed(want.stride_out)));
               if (rsp_extent !== want.extent)
                  report($sformatf("result %0d extent %0d, expected %0d",
                                   result_no, rsp_extent, want.extent));
               if (rsp_error !== want.error)
                  report($sformatf("result %0d error %0d, expected %0d",
                                   result_no, rsp_error, want.error));
               if (rsp_last_out !== want.last_out)
                  report($sformatf("result %0d last_out %0b, expected %0b",
                                   result_no, rsp_last_out, want.last_out));
            end
         end
         if (push && !full)
            predicted_windows.push_back(resolve_entry(req_axis, req_start_req, req_finish,
                                                      req_stride, req_dim, req_out_dim,
                                                      req_last_entry));
         pending_windows <= predicted_windows.size();
         windows_checked <= result_no;
      end
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the slice window resolver. The checker beside the
// block does all prediction and comparison; this module only makes words.
module tb_top;
   import swr_pkg::*;

   localparam longint      IdxMax       = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint      IdxMin       = 64'h8000_0000_0000_0000;
   localparam int unsigned DimMax       = 32'h7FFF_FFFF;
   localparam int          NumPhases    = 9;
   localparam int          PhaseWords   = 155;
   localparam int          HoldPhase    = 1;    // receiver hold-off happens here
   localparam int          QuietPhase   = 7;    // no idling on either side
   localparam int          RxHoldCycles = 300;
   localparam int          DrainSlack   = 40;   // ~block latency after last result
   localparam int          IdleLimit    = 4000; // cycles without any word moving

   typedef struct {
      logic signed [AxisW-1:0] axis;
      logic signed [IdxW-1:0]  start_req;
      logic signed [IdxW-1:0]  finish;
      logic signed [IdxW-1:0]  stride;
      logic [DimW-1:0]         dim;
      logic [DimW-1:0]         out_dim;
      logic                    last_entry;
   } slice_entry_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [CsrIdxW-1:0]      csr_index;
   logic [RankW-1:0]        csr_wdata;
   logic                    push;
   logic                    full;
   logic signed [AxisW-1:0] req_axis;
   logic signed [IdxW-1:0]  req_start_req;
   logic signed [IdxW-1:0]  req_finish;
   logic signed [IdxW-1:0]  req_stride;
   logic [DimW-1:0]         req_dim;
   logic [DimW-1:0]         req_out_dim;
   logic                    req_last_entry;
   logic                    empty;
   logic                    pop;
   logic [AxOutW-1:0]       rsp_axis_out;
   logic [DimW-1:0]         rsp_start_out;
   logic signed [IdxW-1:0]  rsp_stride_out;
   logic [DimW-1:0]         rsp_extent;
   logic [ErrW-1:0]         rsp_error;
   logic                    rsp_last_out;

   int fail_count;
   int pending_windows;
   int windows_checked;

   // idle rates in percent, changed per phase by the stimulus
   int          tx_idle_pct = 7;
   int          rx_idle_pct = 7;
   bit          rx_hold_req = 1'b0;
   int          words_sent  = 0;
   int unsigned cur_rank    = 32'(RankReset);

   // register settings per phase: extremes of rank (0, 1, 8, 15) included
   int unsigned phase_rank[NumPhases]  = '{8, 8, 3, 1, 0, 15, 9, 5, 8};
   bit          phase_axes[NumPhases]  = '{1, 0, 1, 0, 1, 1, 0, 1, 1};
   bit          phase_steps[NumPhases] = '{1, 1, 0, 1, 1, 1, 0, 0, 1};

   slice_window_resolver_core u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .push           (push),
      .full           (full),
      .req_axis       (req_axis),
      .req_start_req  (req_start_req),
      .req_finish     (req_finish),
      .req_stride     (req_stride),
      .req_dim        (req_dim),
      .req_out_dim    (req_out_dim),
      .req_last_entry (req_last_entry),
      .empty          (empty),
      .pop            (pop),
      .rsp_axis_out   (rsp_axis_out),
      .rsp_start_out  (rsp_start_out),
      .rsp_stride_out (rsp_stride_out),
      .rsp_extent     (rsp_extent),
      .rsp_error      (rsp_error),
      .rsp_last_out   (rsp_last_out)
   );

   slice_window_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .push            (push),
      .full            (full),
      .req_axis        (req_axis),
      .req_start_req   (req_start_req),
      .req_finish      (req_finish),
      .req_stride      (req_stride),
      .req_dim         (req_dim),
      .req_out_dim     (req_out_dim),
      .req_last_entry  (req_last_entry),
      .empty           (empty),
      .pop             (pop),
      .rsp_axis_out    (rsp_axis_out),
      .rsp_start_out   (rsp_start_out),
      .rsp_stride_out  (rsp_stride_out),
      .rsp_extent      (rsp_extent),
      .rsp_error       (rsp_error),
      .rsp_last_out    (rsp_last_out),
      .fail_count      (fail_count),
      .pending_windows (pending_windows),
      .windows_checked (windows_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one word and hold it until taken. push stays high across
   // back-to-back words; it drops during a random idle gap or a drain.
   task automatic send_word(input slice_entry_type w);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push           <= 1'b1;
      req_axis       <= w.axis;
      req_start_req  <= w.start_req;
      req_finish     <= w.finish;
      req_stride     <= w.stride;
      req_dim        <= w.dim;
      req_out_dim    <= w.out_dim;
      req_last_entry <= w.last_entry;
      @(posedge clock);
      while (full) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_fields(input int a, input longint s, input longint f,
                              input longint st, input int unsigned d,
                              input int unsigned od, input bit l);
      slice_entry_type w;
      w.axis       = AxisW'(a);
      w.start_req  = s;
      w.finish     = f;
      w.stride     = st;
      w.dim        = DimW'(d);
      w.out_dim    = DimW'(od);
      w.last_entry = l;
      send_word(w);
   endtask

   // start/end: mostly near the dimension, either sign, sometimes wild
   function automatic longint pick_index(input logic [DimW-1:0] dimv);
      int unsigned du;
      longint      v;
      du = 32'(dimv);
      case ($urandom_range(0, 11))
         0:       v = {$urandom, $urandom};
         1:       v = IdxMax;
         2:       v = IdxMin;
         3, 4, 5: v = longint'($urandom_range(0, du + 2));
         6, 7, 8: v = -longint'($urandom_range(0, du + 2));
         9, 10:   v = longint'($urandom_range(0, 20)) - 10;
         default: v = longint'(du) + longint'($urandom_range(0, 6)) - 3;
      endcase
      return v;
   endfunction

   // small steps of either sign most of the time; zero and extremes now and then
   function automatic longint pick_stride();
      longint v;
      case ($urandom_range(0, 19))
         0:       v = 0;
         1:       v = {$urandom, $urandom};
         2:       v = IdxMax;
         3:       v = IdxMin;
         4:       v = longint'($urandom_range(1, 32'h8000_0000));
         default: v = longint'($urandom_range(1, 5));
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   function automatic slice_entry_type random_entry();
      slice_entry_type w;
      int unsigned     pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)      w.dim = '0;
      else if (pick < 8)  w.dim = DimW'($urandom_range(0, 40));
      else                w.dim = DimW'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 5)       w.out_dim = DimW'($urandom_range(0, 50));
      else if (pick < 8)  w.out_dim = DimW'($urandom);
      else                w.out_dim = w.dim;
      w.axis       = AxisW'($urandom);
      w.start_req  = pick_index(w.dim);
      w.finish     = pick_index(w.dim);
      w.stride     = pick_stride();
      w.last_entry = 1'b0;
      return w;
   endfunction

   // One slice spec. Most runs are well formed: distinct valid axes in random
   // order (plain or counted from the back), last set on the final entry.
   // The rest is noise: any axis, duplicates, stray or missing last, and long
   // runs that push the entry position into saturation.
   task automatic send_run();
      int              r_eff;
      int              n;
      int              i;
      int              j;
      int              t;
      bit              clean;
      int              order[8];
      slice_entry_type w;
      r_eff = (cur_rank > 8) ? 8 : int'(cur_rank);
      clean = (r_eff > 0) && ($urandom_range(0, 99) < 80);
      n     = clean ? $urandom_range(1, r_eff) : $urandom_range(1, 20);
      for (i = 0; i < 8; i++) order[i] = i;
      for (i = r_eff - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (i = 0; i < n; i++) begin
         w = random_entry();
         if (clean) begin
            w.axis       = AxisW'($urandom_range(0, 1) ? order[i] : order[i] - r_eff);
            w.last_entry = (i == n - 1);
         end else begin
            if ($urandom_range(0, 1)) w.axis = AxisW'($signed($urandom_range(0, 19)) - 10);
            w.last_entry = (i == n - 1) ? ($urandom_range(0, 3) != 0)
                                        : ($urandom_range(0, 9) == 0);
         end
         send_word(w);
      end
   endtask

   // Stop offering and wait until every predicted result has been taken,
   // then give the block its latency before anything else happens.
   task automatic drain_results();
      push <= 1'b0;
      @(posedge clock);
      while (pending_windows != 0) @(posedge clock);
      repeat (DrainSlack) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [RankW-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int unsigned r, input bit a, input bit s);
      write_csr(CSR_RANK, RankW'(r));
      write_csr(CSR_AXES, RankW'(a));
      write_csr(CSR_STEPS, RankW'(s));
      csr_wr_en <= 1'b0;
      cur_rank = r;
   endtask

   // Hand-picked words at the reset setting (rank 8, axes and steps given).
   task automatic run_directed();
      send_fields(0, 0, 10, 1, 10, 10, 0);                       // plain forward window
      send_fields(0, 2, 5, 1, 10, 10, 0);                        // same axis again
      send_fields(-1, -1, IdxMin, -1, 10, 10, 0);                // axis from back, reverse
      send_fields(1, 0, 5, 0, 10, 10, 0);                        // zero step marks axis
      send_fields(1, 0, 5, 1, 10, 10, 0);                        // axis held by zero step
      send_fields(127, 0, 5, 1, 10, 10, 0);                      // axis far out of range
      send_fields(-128, 0, 5, 1, 10, 10, 0);
      send_fields(-9, 0, 5, 1, 10, 10, 0);                       // still negative after wrap
      send_fields(8, 0, 5, 1, 10, 10, 0);                        // one past rank
      send_fields(2, IdxMin, IdxMax, IdxMax, DimMax, DimMax, 0); // huge step, full span
      send_fields(3, IdxMax, IdxMin, IdxMin, DimMax, DimMax, 0); // most negative step
      send_fields(4, 0, 100, 3, 0, 5, 0);                        // empty dim, forward
      send_fields(5, 7, 0, -2, 0, 5, 0);                         // empty dim, reverse
      send_fields(6, 0, 40, 1, 40, 0, 1);                        // capped to zero, closes run
      send_fields(0, 0, 40, 1, 40, 7, 0);                        // axis free again, cap 7
      send_fields(-8, -3, -1, 1, 20, 20, 0);                     // wraps onto a used axis
      send_fields(1, 5, 5, 1, 20, 20, 0);                        // zero span
      send_fields(2, 10, 2, 1, 20, 20, 0);                       // end before start
      send_fields(3, 0, 20, -1, 20, 20, 0);                      // reverse, start below end
      send_fields(4, 3, 20, 7, 30, 30, 0);                       // rounded-up quotient
      send_fields(5, -1, IdxMax, -3, DimMax, 9, 0);              // reverse from the top
      send_fields(127, IdxMax, IdxMax, IdxMax, DimMax, DimMax, 1); // error entry closes run
   endtask

   // receiver: random pop, plus one long hold-off counted here on request
   initial begin
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            pop <= 1'b0;
            repeat (RxHoldCycles) @(posedge clock);
         end else begin
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // watchdog: ends the run if no word moves on either side for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: no word moved for %0d cycles", IdleLimit);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int  p;
      int  phase_start;
      bit  hold_done;
      reset          = 1'b1;
      push           = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_RANK;
      csr_wdata      = '0;
      req_axis       = '0;
      req_start_req  = '0;
      req_finish     = '0;
      req_stride     = '0;
      req_dim        = '0;
      req_out_dim    = '0;
      req_last_entry = 1'b0;
      hold_done      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (p = 0; p < NumPhases; p++) begin
         // registers only change once the block has gone quiet
         drain_results();
         apply_setting(phase_rank[p], phase_axes[p], phase_steps[p]);
         tx_idle_pct = (p == QuietPhase) ? 0 : 7;
         rx_idle_pct = (p == QuietPhase) ? 0 : 7;
         phase_start = words_sent;
         while (words_sent - phase_start < PhaseWords) begin
            // stall the receiver mid-phase; sender keeps offering until full
            if (p == HoldPhase && !hold_done && words_sent - phase_start >= PhaseWords / 3) begin
               rx_hold_req = 1'b1;
               hold_done   = 1'b1;
            end
            send_run();
         end
      end

      drain_results();
      $display("Summary: %0d words sent, %0d results checked, %0d register settings",
               words_sent, windows_checked, NumPhases + 1);
      $display("Summary: ranks 0 to 15, axes/steps on and off, a %0d-cycle receiver stall",
               RxHoldCycles);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[slice_window_resolver_core.f]
src/swr_pkg.sv
src/swr_front.sv
src/swr_queue.sv
src/swr_back.sv
src/slice_window_resolver_core.sv
dv/slice_window_checker.sv
dv/tb_top.sv
